// ===== hdl/wma3_pkg.sv =====
// ----------------------------------------------------------------------------
// wma3_pkg
// Shared types and constants of the three-channel windowed moving average.
// ----------------------------------------------------------------------------
package wma3_pkg;

	localparam int SITES_DEF      = 8;
	localparam int MAX_WINDOW_DEF = 256;

	localparam int CHANNELS = 3;
	localparam int SAMPLE_W = 16;
	localparam int SUM_W    = 24;
	localparam int COUNT_W  = 16;
	localparam int WIN_W    = 9;
	localparam int SITE_IN_W = 3;

	localparam logic [WIN_W-1:0]   WINDOW_RESET = 9'd200;
	localparam logic [COUNT_W-1:0] COUNT_MAX    = 16'hFFFF;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [SUM_W-1:0]    sum_t;

	// Per-request control that the sequencer sends to every channel lane.
	typedef struct packed {
		logic start;
		logic drop;
	} lane_ctrl_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_READ,
		ST_UPD,
		ST_DIV,
		ST_OUT
	} wma3_state_t;

endpackage

// ===== hdl/wma3_ram.sv =====
// ----------------------------------------------------------------------------
// wma3_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module wma3_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 2048,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ===== hdl/wma3_div.sv =====
// ----------------------------------------------------------------------------
// wma3_div
// Restoring divider, one quotient bit per cycle: signed running sum by an
// unsigned divisor, truncated toward zero and saturated to 16 bits.
// ----------------------------------------------------------------------------
module wma3_div #(
	parameter int DEN_W = 9
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  wma3_pkg::sum_t          num,
	input  logic [DEN_W-1:0]        den,
	output wma3_pkg::sample_t       quot,
	output logic                    done
);

	localparam int NUM_W  = wma3_pkg::SUM_W;
	localparam int STEP_W = $clog2(NUM_W + 1);

	logic              busy_q;
	logic              fin_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic              neg_q;
	logic [NUM_W-1:0]  quo_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	wma3_pkg::sample_t avg_q;

	logic [DEN_W:0]    trial;
	logic              ge;
	logic [DEN_W:0]    trial_sub;
	logic [15:0]       neg_lo;

	assign trial     = {rem_q, quo_q[NUM_W-1]};
	assign ge        = trial >= {1'b0, den_q};
	assign trial_sub = trial - {1'b0, den_q};
	assign neg_lo    = ~quo_q[15:0] + 16'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				fin_q  <= 1'b0;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[NUM_W-1];
			quo_q <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
		if (fin_q) begin
			// Magnitude quotient is saturated before the sign is put back.
			if (!neg_q) begin
				avg_q <= (quo_q > NUM_W'(32767)) ? 16'sh7FFF : wma3_pkg::sample_t'(quo_q[15:0]);
			end else begin
				avg_q <= (quo_q > NUM_W'(32768)) ? 16'sh8000 : wma3_pkg::sample_t'(neg_lo);
			end
		end
	end

	assign quot = avg_q;
	assign done = done_q;

endmodule

// ===== hdl/wma3_lane.sv =====
// ----------------------------------------------------------------------------
// wma3_lane
// One channel lane: updates the running sum with the new sample, drops the
// oldest sample once the window is full, and divides the sum for the average.
// ----------------------------------------------------------------------------
module wma3_lane #(
	parameter int DEN_W = 9
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  wma3_pkg::lane_ctrl_t ctrl,
	input  wma3_pkg::sum_t       sum_old,
	input  wma3_pkg::sample_t    oldest,
	input  wma3_pkg::sample_t    sample,
	input  logic [DEN_W-1:0]     den,
	output wma3_pkg::sum_t       sum_new,
	output wma3_pkg::sample_t    avg,
	output logic                 done
);

	localparam int SUM_W = wma3_pkg::SUM_W;
	localparam int EXT_W = wma3_pkg::SUM_W - wma3_pkg::SAMPLE_W;

	wma3_pkg::sum_t sum_next;
	wma3_pkg::sum_t sum_q;
	wma3_pkg::sum_t old_ext;
	wma3_pkg::sum_t smp_ext;

	assign old_ext  = ctrl.drop ? {{EXT_W{oldest[15]}}, oldest} : '0;
	assign smp_ext  = {{EXT_W{sample[15]}}, sample};
	// The sum wraps at 24 bits, as two's complement.
	assign sum_next = SUM_W'(sum_old - old_ext + smp_ext);

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			sum_q <= sum_next;
		end
	end

	wma3_div #(
		.DEN_W(DEN_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (ctrl.start),
		.num   (sum_next),
		.den   (den),
		.quot  (avg),
		.done  (done)
	);

	assign sum_new = sum_q;

endmodule

// ===== hdl/windowed_moving_average_3ch.sv =====
// ----------------------------------------------------------------------------
// windowed_moving_average_3ch
// Per-site boxcar moving average of three sample channels.
// ----------------------------------------------------------------------------
// A request on the s_axis channel carries one site's vref, buck and iref
// samples; each request produces exactly one result on m_axis with the
// three averages, the site's saturating sample count and a window-full flag.
// cfg_we/cfg_wdata set the window length; the user alone must see that it is
// written only while the block idles. A good-bin request passes through the
// states LOOK, READ, UPD, DIV and OUT before the next ready: three lanes run
// side by side, each with a restoring divider that delivers one quotient bit
// per cycle over the 24-bit sum, and the ring store is one read and one write.
// A bad-bin request or a site out of range goes from LOOK straight to OUT.
// After reset the ring store is swept to zero, one entry a cycle, over all
// SITES * MAX_WINDOW entries (2048 with the defaults); s_axis_tready stays
// low until the sweep ends. A result is held in an output register, so a
// stalled receiver does not block the next request from being taken; the
// block then waits with its next result until the register is free.
// ----------------------------------------------------------------------------
module windowed_moving_average_3ch #(
	parameter int SITES      = wma3_pkg::SITES_DEF,
	parameter int MAX_WINDOW = wma3_pkg::MAX_WINDOW_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [8:0]  cfg_wdata,      // window_len
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // vref_sample, buck_sample, iref_sample
	input  logic [3:0]  s_axis_tuser,   // site, bad_bin
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // vref_avg, buck_avg, iref_avg, sample_count
	output logic [0:0]  m_axis_tuser    // window_full
);

	localparam int CH      = wma3_pkg::CHANNELS;
	localparam int SW      = wma3_pkg::SAMPLE_W;
	localparam int CW      = wma3_pkg::COUNT_W;
	localparam int DEPTH   = SITES * MAX_WINDOW;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int SITE_W  = (SITES > 1) ? $clog2(SITES) : 1;
	localparam int SLOT_W  = $clog2(MAX_WINDOW);
	localparam int DEN_W   = $clog2(MAX_WINDOW + 1);

	wma3_pkg::wma3_state_t state_q, state_d;

	logic [wma3_pkg::WIN_W-1:0] window_q;
	logic [ADDR_W-1:0]          clr_q;
	logic [CW-1:0]              count_q [SITES];
	logic [SLOT_W-1:0]          slot_q  [SITES];
	wma3_pkg::sum_t             sum_q   [SITES][CH];
	wma3_pkg::sample_t          held_q  [SITES][CH];

	logic [wma3_pkg::SITE_IN_W-1:0] site_q;
	logic                           bad_q;
	wma3_pkg::sample_t              smp_q [CH];

	logic [CW-1:0]     cnt_new_q;
	logic [SLOT_W-1:0] slot_new_q;
	logic              fill_q;
	logic [DEN_W-1:0]  den_q;
	logic [ADDR_W-1:0] addr_q;

	logic              m_tvalid_q;
	wma3_pkg::sample_t out_avg_q [CH];
	logic              out_full_q;
	logic [CW-1:0]     out_count_q;

	logic [DEN_W-1:0]  weff;
	logic [SITE_W-1:0] site_idx;
	logic              site_ok;
	logic [CW-1:0]     cur_count;
	logic [CW-1:0]     cnt_next;
	logic [SLOT_W:0]   slot_inc;
	logic [SLOT_W-1:0] slot_next;
	logic              fill_next;
	logic              out_free;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_addr;
	logic [3*SW-1:0]   ram_wdata;
	logic [3*SW-1:0]   ram_rdata;

	wma3_pkg::lane_ctrl_t lane_ctrl;
	wma3_pkg::sum_t       lane_sum  [CH];
	wma3_pkg::sample_t    lane_avg  [CH];
	logic [CH-1:0]        lane_done;
	logic                 all_done;

	// Window clamped to the range the ring store supports.
	always_comb begin
		if (window_q < wma3_pkg::WIN_W'(2)) begin
			weff = DEN_W'(2);
		end else if (32'(window_q) > MAX_WINDOW) begin
			weff = DEN_W'(MAX_WINDOW);
		end else begin
			weff = DEN_W'(window_q);
		end
	end

	assign site_idx  = SITE_W'(site_q);
	assign site_ok   = 32'(site_q) < SITES;
	assign cur_count = count_q[site_idx];
	assign cnt_next  = (cur_count == wma3_pkg::COUNT_MAX) ? cur_count : cur_count + CW'(1);
	assign slot_inc  = {1'b0, slot_q[site_idx]} + (SLOT_W+1)'(1);
	assign slot_next = (32'(slot_inc) >= 32'(weff)) ? '0 : slot_inc[SLOT_W-1:0];
	assign fill_next = cnt_next < CW'(weff);
	assign out_free  = !m_tvalid_q || m_axis_tready;
	assign all_done  = &lane_done;

	always_comb begin
		state_d         = state_q;
		s_axis_tready   = 1'b0;
		ram_we          = 1'b0;
		lane_ctrl.start = 1'b0;
		lane_ctrl.drop  = !fill_q;
		unique case (state_q)
			wma3_pkg::ST_CLEAR: begin
				ram_we = 1'b1;
				if (clr_q == ADDR_W'(DEPTH - 1)) begin
					state_d = wma3_pkg::ST_IDLE;
				end
			end
			wma3_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = wma3_pkg::ST_LOOK;
				end
			end
			wma3_pkg::ST_LOOK: begin
				if (site_ok && !bad_q) begin
					state_d = wma3_pkg::ST_READ;
				end else begin
					state_d = wma3_pkg::ST_OUT;
				end
			end
			wma3_pkg::ST_READ: begin
				state_d = wma3_pkg::ST_UPD;
			end
			wma3_pkg::ST_UPD: begin
				ram_we          = 1'b1;
				lane_ctrl.start = 1'b1;
				state_d         = wma3_pkg::ST_DIV;
			end
			wma3_pkg::ST_DIV: begin
				if (all_done) begin
					state_d = wma3_pkg::ST_OUT;
				end
			end
			wma3_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = wma3_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = wma3_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= wma3_pkg::ST_CLEAR;
			window_q   <= wma3_pkg::WINDOW_RESET;
			clr_q      <= '0;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < SITES; i++) begin
				count_q[i] <= '0;
				slot_q[i]  <= '0;
				for (int c = 0; c < CH; c++) begin
					sum_q[i][c]  <= '0;
					held_q[i][c] <= '0;
				end
			end
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				window_q <= cfg_wdata;
			end
			if (state_q == wma3_pkg::ST_CLEAR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			// A bad bin on a site that has counted nothing reads zero.
			if (state_q == wma3_pkg::ST_LOOK && site_ok && bad_q && cur_count == '0) begin
				for (int c = 0; c < CH; c++) begin
					held_q[site_idx][c] <= '0;
				end
			end
			if (state_q == wma3_pkg::ST_DIV && all_done) begin
				count_q[site_idx] <= cnt_new_q;
				slot_q[site_idx]  <= slot_new_q;
				for (int c = 0; c < CH; c++) begin
					sum_q[site_idx][c]  <= lane_sum[c];
					held_q[site_idx][c] <= lane_avg[c];
				end
			end
			if (state_q == wma3_pkg::ST_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			site_q <= s_axis_tuser[2:0];
			bad_q  <= s_axis_tuser[3];
			for (int c = 0; c < CH; c++) begin
				smp_q[c] <= wma3_pkg::sample_t'(s_axis_tdata[c*SW +: SW]);
			end
		end
		if (state_q == wma3_pkg::ST_LOOK) begin
			cnt_new_q  <= cnt_next;
			slot_new_q <= slot_next;
			fill_q     <= fill_next;
			den_q      <= fill_next ? cnt_next[DEN_W-1:0] : weff;
			addr_q     <= ADDR_W'(32'(site_idx) * MAX_WINDOW + 32'(slot_next));
		end
		if (state_q == wma3_pkg::ST_OUT && out_free) begin
			for (int c = 0; c < CH; c++) begin
				out_avg_q[c] <= site_ok ? held_q[site_idx][c] : '0;
			end
			out_full_q  <= site_ok && (cur_count >= CW'(weff));
			out_count_q <= site_ok ? cur_count : '0;
		end
	end

	assign ram_addr  = (state_q == wma3_pkg::ST_CLEAR) ? clr_q : addr_q;
	assign ram_wdata = (state_q == wma3_pkg::ST_CLEAR) ? '0 : {smp_q[2], smp_q[1], smp_q[0]};

	wma3_ram #(
		.WIDTH(3 * SW),
		.DEPTH(DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	for (genvar g = 0; g < CH; g++) begin : g_lane
		wma3_lane #(
			.DEN_W(DEN_W)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (lane_ctrl),
			.sum_old(sum_q[site_idx][g]),
			.oldest (wma3_pkg::sample_t'(ram_rdata[g*SW +: SW])),
			.sample (smp_q[g]),
			.den    (den_q),
			.sum_new(lane_sum[g]),
			.avg    (lane_avg[g]),
			.done   (lane_done[g])
		);
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = {out_count_q, out_avg_q[2], out_avg_q[1], out_avg_q[0]};
	assign m_axis_tuser  = out_full_q;

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		lane_done[0] |-> state_q == wma3_pkg::ST_DIV)
		else $error("lane finished outside the divide phase");

	a_lanes_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(lane_done) == 0 || $countones(lane_done) == CH)
		else $error("channel lanes out of step");

	a_slot_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == wma3_pkg::ST_UPD |-> 32'(slot_new_q) < 32'(weff))
		else $error("ring slot beyond the window");

	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == wma3_pkg::ST_UPD |-> den_q != '0)
		else $error("zero divisor issued to the lanes");

	a_result_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q) == wma3_pkg::ST_OUT)
		else $error("result loaded outside the output phase");

endmodule
